// File: src/scba_pkg.sv
// ----------------------------------------------------------------------------
// Size-class block allocator package
// Shared constants, request and status codes for the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scba_pkg;

    localparam int BLOCKS_PER_CLASS = 256;
    localparam int NUM_CLASSES      = 7;
    localparam int MAX_POOL_SIZE    = 4096;

    localparam int MIN_BLOCK_BYTES  = 64;
    localparam int SIZE_W           = 16;
    localparam int CLS_W            = 3;
    localparam int IDX_W            = 8;
    localparam int REF_W            = 8;
    localparam int CFG_W            = 9;
    localparam int NUM_CFG          = 7;
    localparam int CFG_IDX_W        = 3;
    localparam int SCAN_STEPS       = 16;

    localparam int BLK_W            = $clog2(BLOCKS_PER_CLASS + 1);
    localparam int STORE_DEPTH      = NUM_CLASSES * BLOCKS_PER_CLASS;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);

    localparam logic [BLK_W-1:0] EMPTY_MARK = BLK_W'(BLOCKS_PER_CLASS);
    localparam logic [REF_W-1:0] REF_MAX    = '1;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_ADDREF = 2'd2,
        REQ_NOP    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_REF_ERR   = 2'd3
    } status_t;

    typedef struct packed {
        logic             too_large;
        logic [CLS_W-1:0] cls;
    } size_map_t;

endpackage

// File: src/scba_size_map.sv
// ----------------------------------------------------------------------------
// Size-class mapper
// Maps a requested byte size to the smallest size class that fits it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scba_size_map
(
    input  logic [scba_pkg::SIZE_W-1:0] req_size,
    output scba_pkg::size_map_t         map
);

    logic [scba_pkg::SCAN_STEPS-1:0] above;
    logic [4:0]                      steps;

    always_comb
    begin
        for (int k = 0; k < scba_pkg::SCAN_STEPS; k++)
        begin
            above[k] = 32'(req_size) > (scba_pkg::MIN_BLOCK_BYTES << k);
        end
        steps = 5'($countones(above));
        map.cls = steps[scba_pkg::CLS_W-1:0];
        map.too_large = (32'(req_size) > scba_pkg::MAX_POOL_SIZE) ||
                        (32'(steps) >= scba_pkg::NUM_CLASSES);
    end

endmodule

// File: src/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// Size-class block allocator
// Fixed-block buffer manager with per-class free lists and reference counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// On acceptance of a request word, its block's entry (free link and reference
// count) is read from the single-port store; S_EXEC then modifies it, writes
// it back and loads the result register. s_tready is low in S_EXEC, which
// lasts while a finished result cannot yet leave. A result may wait
// in the output register while the next word is accepted. There is no clearing
// pass after reset: a reference count reads as zero for any block at or above
// its class's fresh hand-out point, so the store needs no initialization.

module size_class_block_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // req_size, handle_class, handle_index
    input  logic [1:0]                      s_tuser,   // req_type

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // block_class, block_index, ref_after
    output logic [1:0]                      m_tuser,   // status

    input  logic                            cfg_we,
    input  logic [scba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scba_pkg::CFG_W-1:0]      cfg_data
);

    localparam int BLK_W  = scba_pkg::BLK_W;
    localparam int ADDR_W = scba_pkg::ADDR_W;
    localparam int CLS_W  = scba_pkg::CLS_W;
    localparam int IDX_W  = scba_pkg::IDX_W;
    localparam int REF_W  = scba_pkg::REF_W;

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    typedef struct packed {
        logic [BLK_W-1:0] link;
        logic [REF_W-1:0] refs;
    } entry_t;

    state_t                 state_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic [CLS_W-1:0]       out_cls_reg;
    logic [IDX_W-1:0]       out_idx_reg;
    logic [REF_W-1:0]       out_ref_reg;

    logic [BLK_W-1:0]       free_head_reg   [scba_pkg::NUM_CLASSES];
    logic [BLK_W-1:0]       next_unused_reg [scba_pkg::NUM_CLASSES];
    logic [scba_pkg::CFG_W-1:0] cap_reg     [scba_pkg::NUM_CFG];

    entry_t                 mem [scba_pkg::STORE_DEPTH];
    entry_t                 rd_reg;

    scba_pkg::req_type_t    type_reg;
    logic [CLS_W-1:0]       cls_reg;
    logic [BLK_W-1:0]       blk_reg;
    logic [BLK_W-1:0]       head_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   too_large_reg;
    logic                   pop_reg;
    logic                   fresh_reg;
    logic                   handle_ok_reg;
    logic                   live_reg;

    scba_pkg::size_map_t    size_map;
    scba_pkg::req_type_t    in_type;
    logic [CLS_W-1:0]       hcls;
    logic [IDX_W-1:0]       hidx;
    logic [CLS_W-1:0]       sel_cls;
    logic                   cls_ok;
    logic [BLK_W-1:0]       head_sel;
    logic [BLK_W-1:0]       nu_sel;
    logic [BLK_W-1:0]       cap_sel;
    logic                   in_pop;
    logic                   in_fresh;
    logic                   in_live;
    logic                   in_handle_ok;
    logic [BLK_W-1:0]       in_blk;
    logic [ADDR_W-1:0]      in_addr;
    logic                   accept;

    logic                   out_free;
    logic                   exec_done;
    logic [REF_W-1:0]       ref_now;
    logic [REF_W-1:0]       ref_new;
    logic [1:0]             res_status;
    logic [CLS_W-1:0]       res_cls;
    logic [IDX_W-1:0]       res_idx;
    logic [REF_W-1:0]       res_ref;
    logic                   mem_we;
    entry_t                 mem_wdata;
    logic                   head_we;
    logic [BLK_W-1:0]       head_wval;
    logic                   nu_we;

    scba_size_map u_size_map
    (
        .req_size (s_tdata[15:0]),
        .map      (size_map)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'd0, out_ref_reg, out_idx_reg, out_cls_reg};

    always_comb
    begin
        in_type  = scba_pkg::req_type_t'(s_tuser);
        hcls     = s_tdata[18:16];
        hidx     = s_tdata[26:19];
        sel_cls  = (in_type == scba_pkg::REQ_ALLOC) ? size_map.cls : hcls;
        cls_ok   = 32'(sel_cls) < scba_pkg::NUM_CLASSES;
        head_sel = scba_pkg::EMPTY_MARK;
        nu_sel   = '0;
        cap_sel  = BLK_W'(scba_pkg::BLOCKS_PER_CLASS);
        if (cls_ok)
        begin
            head_sel = free_head_reg[sel_cls];
            nu_sel   = next_unused_reg[sel_cls];
        end
        if (32'(sel_cls) < scba_pkg::NUM_CFG)
        begin
            if (32'(cap_reg[sel_cls]) < scba_pkg::BLOCKS_PER_CLASS)
            begin
                cap_sel = BLK_W'(cap_reg[sel_cls]);
            end
        end
        in_pop       = head_sel < scba_pkg::EMPTY_MARK;
        in_fresh     = nu_sel < cap_sel;
        in_live      = BLK_W'(hidx) < nu_sel;
        in_handle_ok = cls_ok && (32'(hidx) < scba_pkg::BLOCKS_PER_CLASS);
        if (in_type == scba_pkg::REQ_ALLOC)
        begin
            in_blk = in_pop ? head_sel : nu_sel;
        end
        else
        begin
            in_blk = BLK_W'(hidx);
        end
        if (cls_ok && (32'(in_blk) < scba_pkg::BLOCKS_PER_CLASS))
        begin
            in_addr = ADDR_W'(32'(sel_cls) * scba_pkg::BLOCKS_PER_CLASS + 32'(in_blk));
        end
        else
        begin
            in_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg        <= mem[in_addr];
            type_reg      <= in_type;
            cls_reg       <= sel_cls;
            blk_reg       <= in_blk;
            head_reg      <= head_sel;
            addr_reg      <= in_addr;
            too_large_reg <= size_map.too_large;
            pop_reg       <= in_pop;
            fresh_reg     <= in_fresh;
            handle_ok_reg <= in_handle_ok;
            live_reg      <= in_live;
        end
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
    end

    always_comb
    begin
        out_free   = !out_valid_reg || m_tready;
        exec_done  = (state_reg == S_EXEC) && out_free;
        ref_now    = live_reg ? rd_reg.refs : '0;
        ref_new    = ref_now;
        res_status = scba_pkg::ST_REF_ERR;
        res_cls    = '0;
        res_idx    = '0;
        res_ref    = '0;
        mem_we     = 1'b0;
        mem_wdata  = rd_reg;
        head_we    = 1'b0;
        head_wval  = rd_reg.link;
        nu_we      = 1'b0;
        unique case (type_reg)
            scba_pkg::REQ_ALLOC:
            begin
                if (too_large_reg)
                begin
                    res_status = scba_pkg::ST_TOO_LARGE;
                end
                else if (pop_reg || fresh_reg)
                begin
                    res_status     = scba_pkg::ST_OK;
                    res_cls        = cls_reg;
                    res_idx        = blk_reg[IDX_W-1:0];
                    res_ref        = REF_W'(1);
                    mem_we         = exec_done;
                    mem_wdata.refs = REF_W'(1);
                    head_we        = exec_done && pop_reg;
                    nu_we          = exec_done && !pop_reg;
                end
                else
                begin
                    res_status = scba_pkg::ST_EXHAUSTED;
                    res_cls    = cls_reg;
                end
            end
            scba_pkg::REQ_FREE,
            scba_pkg::REQ_ADDREF:
            begin
                res_cls = cls_reg;
                res_idx = blk_reg[IDX_W-1:0];
                if (handle_ok_reg && (ref_now != '0))
                begin
                    if (type_reg == scba_pkg::REQ_FREE)
                    begin
                        ref_new = ref_now - REF_W'(1);
                    end
                    else if (ref_now != scba_pkg::REF_MAX)
                    begin
                        ref_new = ref_now + REF_W'(1);
                    end
                    res_status     = scba_pkg::ST_OK;
                    res_ref        = ref_new;
                    mem_we         = exec_done;
                    mem_wdata.refs = ref_new;
                    if ((type_reg == scba_pkg::REQ_FREE) && (ref_new == '0))
                    begin
                        mem_wdata.link = head_reg;
                        head_we        = exec_done;
                        head_wval      = blk_reg;
                    end
                end
            end
            default:
            begin
                res_status = scba_pkg::ST_REF_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_cls_reg    <= '0;
            out_idx_reg    <= '0;
            out_ref_reg    <= '0;
            for (int k = 0; k < scba_pkg::NUM_CLASSES; k++)
            begin
                free_head_reg[k]   <= scba_pkg::EMPTY_MARK;
                next_unused_reg[k] <= '0;
            end
            for (int k = 0; k < scba_pkg::NUM_CFG; k++)
            begin
                cap_reg[k] <= scba_pkg::CFG_W'(scba_pkg::BLOCKS_PER_CLASS);
            end
        end
        else
        begin
            if (cfg_we && (32'(cfg_index) < scba_pkg::NUM_CFG))
            begin
                cap_reg[cfg_index] <= cfg_data;
            end
            if (m_tready && !exec_done)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        state_reg      <= S_IDLE;
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status;
                        out_cls_reg    <= res_cls;
                        out_idx_reg    <= res_idx;
                        out_ref_reg    <= res_ref;
                        if (head_we)
                        begin
                            free_head_reg[cls_reg] <= head_wval;
                        end
                        if (nu_we)
                        begin
                            next_unused_reg[cls_reg] <= blk_reg + BLK_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/scba_checker.sv
// ----------------------------------------------------------------------------
// Size-class block allocator checker
// Port-level assertions on the allocator's stream behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scba_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result word must hold its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // Each request word occupies the block for its modify cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted during modify cycle");

    // A successful result names a real size class.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == scba_pkg::ST_OK) |->
        (32'(m_tdata[2:0]) < scba_pkg::NUM_CLASSES))
        else $error("ok result with bad class");

    // Rejected allocations carry no block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == scba_pkg::ST_EXHAUSTED) ||
                     (m_tuser == scba_pkg::ST_TOO_LARGE)) |-> (m_tdata[18:3] == 16'd0))
        else $error("rejected allocation carries a block");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
